>>> rtl/gdr_pkg.sv
// ----------------------------------------------------------------------------
// gdr_pkg
// Shared types, widths and codes of the grid column raycaster.
// ----------------------------------------------------------------------------
package gdr_pkg;

    localparam int MAP_SIZE_D      = 32;
    localparam int SCREEN_WIDTH_D  = 640;
    localparam int SCREEN_HEIGHT_D = 480;
    localparam int TEX_SIZE_D      = 64;

    localparam int CAMX_W     = 25;
    localparam int RD_W       = 28;
    localparam int DIVN_W     = 33;
    localparam int DIVD_W     = 28;
    localparam int DD_W       = 41;
    localparam int SD_W       = 51;
    localparam int D_W        = 24;
    localparam int LH_W       = 29;
    localparam int TEXV_W     = 22;
    localparam int QDEPTH     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y = 3'd5;

    typedef struct packed {
        logic       op;
        logic [4:0] x;
        logic [4:0] y;
        logic [3:0] val;
        logic [9:0] col;
    } t_item;

    typedef struct packed {
        logic [20:0] pos_x;
        logic [20:0] pos_y;
        logic [17:0] dir_x;
        logic [17:0] dir_y;
        logic [17:0] plane_x;
        logic [17:0] plane_y;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] num;
        logic [DIVD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVN_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic [9:0]        column_out;
        logic              hit_side;
        logic [2:0]        texture_index;
        logic [D_W-1:0]    wall_distance;
        logic [8:0]        span_start;
        logic [8:0]        span_end;
        logic [5:0]        texture_column;
        logic [TEXV_W-1:0] texture_step;
        logic [TEXV_W-1:0] texture_start;
        logic              left_map;
    } t_result;

endpackage

>>> rtl/gdr_div.sv
// ----------------------------------------------------------------------------
// gdr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdr_pkg::t_div_req i_req,
    output gdr_pkg::t_div_rsp o_rsp
);

    localparam int NW = gdr_pkg::DIVN_W;
    localparam int DW = gdr_pkg::DIVD_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_num[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[NW-2:0], 1'b0};
                r_quot <= {r_quot[NW-2:0], fits};
                r_rem  <= fits ? DW'(trial - {1'b0, r_den}) : DW'(trial);
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> rtl/gdr_queue.sv
// ----------------------------------------------------------------------------
// gdr_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module gdr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gdr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output gdr_pkg::t_item o_item,
    output logic           o_empty
);

    localparam int PW = $clog2(gdr_pkg::QDEPTH);

    gdr_pkg::t_item r_mem [gdr_pkg::QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = r_cnt == (PW+1)'(gdr_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

endmodule

>>> rtl/gdr_front.sv
// ----------------------------------------------------------------------------
// gdr_front
// Input stage: takes words, drops map writes outside the map, feeds the queue.
// ----------------------------------------------------------------------------
module gdr_front #(
    parameter int MAP_SIZE = gdr_pkg::MAP_SIZE_D
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic           i_mode,
    input  logic [4:0]     i_cell_x,
    input  logic [4:0]     i_cell_y,
    input  logic [3:0]     i_cell_value,
    input  logic [9:0]     i_screen_column,
    output logic           o_q_push,
    output gdr_pkg::t_item o_q_item,
    input  logic           i_q_full
);

    logic           r_valid;
    gdr_pkg::t_item r_item;
    logic           accept;
    logic           keep;

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_item = r_item;
    assign keep     = (i_mode == gdr_pkg::OP_CAST) ||
                      ((int'(i_cell_x) < MAP_SIZE) && (int'(i_cell_y) < MAP_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op  <= i_mode;
            r_item.x   <= i_cell_x;
            r_item.y   <= i_cell_y;
            r_item.val <= i_cell_value;
            r_item.col <= i_screen_column;
        end
    end

endmodule

>>> rtl/gdr_back.sv
// ----------------------------------------------------------------------------
// gdr_back
// Execution engine: map store, ray setup, cell walk and wall slice math.
// ----------------------------------------------------------------------------
module gdr_back #(
    parameter int MAP_SIZE      = gdr_pkg::MAP_SIZE_D,
    parameter int SCREEN_WIDTH  = gdr_pkg::SCREEN_WIDTH_D,
    parameter int SCREEN_HEIGHT = gdr_pkg::SCREEN_HEIGHT_D,
    parameter int TEX_SIZE      = gdr_pkg::TEX_SIZE_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdr_pkg::t_cfg     i_cfg,
    input  logic              i_q_empty,
    input  gdr_pkg::t_item    i_q_item,
    output logic              o_q_pop,
    output gdr_pkg::t_div_req o_div_req,
    input  gdr_pkg::t_div_rsp i_div_rsp,
    output gdr_pkg::t_result  o_res,
    output logic              o_res_valid,
    input  logic              i_res_pop
);

    localparam int AW         = $clog2(MAP_SIZE);
    localparam int MW         = ((AW > 5) ? AW : 5) + 2;
    localparam int DEPTH      = 1 << (2 * AW);
    localparam int STEP_LIMIT = 2 * MAP_SIZE + 4;
    localparam int NW         = $clog2(STEP_LIMIT + 1);
    localparam int H2         = SCREEN_HEIGHT / 2;
    localparam int CAMX_W     = gdr_pkg::CAMX_W;
    localparam int RD_W       = gdr_pkg::RD_W;
    localparam int DIVN_W     = gdr_pkg::DIVN_W;
    localparam int DIVD_W     = gdr_pkg::DIVD_W;
    localparam int DD_W       = gdr_pkg::DD_W;
    localparam int SD_W       = gdr_pkg::SD_W;
    localparam int D_W        = gdr_pkg::D_W;
    localparam int LH_W       = gdr_pkg::LH_W;
    localparam int TEXV_W     = gdr_pkg::TEXV_W;
    localparam logic [TEXV_W-1:0] TEX_MAX = {TEXV_W{1'b1}};
    localparam logic [D_W-1:0]    D_MAX   = {D_W{1'b1}};

    // The camera offset is split as cabs * 65536 = cabs * CQ * W + cabs * CR,
    // and the small remainder term is divided by a reciprocal multiply.
    localparam int     CQ = 65536 / SCREEN_WIDTH;
    localparam int     CR = 65536 % SCREEN_WIDTH;
    localparam longint CM = (longint'(1) << 32) / SCREEN_WIDTH;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_WAIT  = 5'd2;
    localparam logic [4:0] S_RAY   = 5'd3;
    localparam logic [4:0] S_RX    = 5'd4;
    localparam logic [4:0] S_RY    = 5'd5;
    localparam logic [4:0] S_SIDE  = 5'd6;
    localparam logic [4:0] S_STEP  = 5'd7;
    localparam logic [4:0] S_CHECK = 5'd8;
    localparam logic [4:0] S_DIST  = 5'd9;
    localparam logic [4:0] S_LH    = 5'd10;
    localparam logic [4:0] S_WALL  = 5'd11;
    localparam logic [4:0] S_TEXX  = 5'd12;
    localparam logic [4:0] S_TPOS  = 5'd13;
    localparam logic [4:0] S_OUT   = 5'd14;
    localparam logic [4:0] S_CAMA  = 5'd15;
    localparam logic [4:0] S_CAMB  = 5'd16;
    localparam logic [4:0] S_CAMC  = 5'd17;

    localparam logic [2:0] DK_DDX  = 3'd1;
    localparam logic [2:0] DK_DDY  = 3'd2;
    localparam logic [2:0] DK_LH   = 3'd3;
    localparam logic [2:0] DK_STEP = 3'd4;

    logic [4:0]               r_state;
    logic [2*AW-1:0]          r_clr;
    logic [2:0]               r_kind;
    logic                     r_dgo;
    logic [DIVN_W-1:0]        r_dnum;
    logic [DIVD_W-1:0]        r_dden;
    logic                     r_neg;
    logic [12:0]              r_cab;
    logic [28:0]              r_cq;
    logic [24:0]              r_cx;
    logic [12:0]              r_q1;
    logic [9:0]               r_col;
    logic signed [CAMX_W-1:0] r_camx;
    logic signed [RD_W-1:0]   r_rdx;
    logic signed [RD_W-1:0]   r_rdy;
    logic [DD_W-1:0]          r_ddx;
    logic [DD_W-1:0]          r_ddy;
    logic [SD_W-1:0]          r_sdx;
    logic [SD_W-1:0]          r_sdy;
    logic [MW-1:0]            r_mx;
    logic [MW-1:0]            r_my;
    logic [NW-1:0]            r_n;
    logic                     r_side;
    logic                     r_left;
    logic [3:0]               r_cell;
    logic [D_W-1:0]           r_d;
    logic [LH_W-1:0]          r_lh;
    logic [11:0]              r_start;
    logic [11:0]              r_end;
    logic [LH_W-2:0]          r_k;
    logic [15:0]              r_wfrac;
    logic [7:0]               r_texx;
    logic [TEXV_W-1:0]        r_step;
    logic [TEXV_W-1:0]        r_tpos;
    gdr_pkg::t_result         r_res;
    logic                     r_ov;
    logic [3:0]               r_map [DEPTH];

    logic signed [13:0]        cdiff;
    logic [12:0]               cabs;
    logic [56:0]               cprod;
    logic [24:0]               crem;
    logic                      cfix;
    logic [CAMX_W-1:0]         cmag;
    logic signed [CAMX_W+17:0] px;
    logic signed [CAMX_W+17:0] py;
    logic [DIVD_W-1:0]         rabsx;
    logic [DIVD_W-1:0]         rabsy;
    logic [16:0]               fx;
    logic [16:0]               fy;
    logic [49:0]               psx;
    logic [49:0]               psy;
    logic [SD_W-1:0]           sdx0;
    logic [SD_W-1:0]           sdy0;
    logic [MW-1:0]             mx0;
    logic [MW-1:0]             my0;
    logic                      take_x;
    logic [MW-1:0]             nmx;
    logic [MW-1:0]             nmy;
    logic                      out_map;
    logic [SD_W:0]             dsub;
    logic [D_W-1:0]            dsat;
    logic [31:0]               wprod;
    logic [24:0]               tprod;
    logic [8:0]                texx0;
    logic                      mirror;
    logic [LH_W-2:0]           half;
    logic [43:0]               tp;
    logic [DIVN_W-1:0]         q;
    logic                      mem_we;
    logic [2*AW-1:0]           mem_wa;
    logic [3:0]                mem_wd;
    logic [2*AW-1:0]           mem_ra;

    assign q = i_div_rsp.quot;

    assign cdiff = $signed(14'({i_q_item.col, 1'b0})) - $signed(14'(SCREEN_WIDTH));
    assign cabs  = cdiff[13] ? 13'(-cdiff) : 13'(cdiff);

    assign cprod = 57'(r_cx) * 57'(CM);
    assign crem  = r_cx - 25'(r_q1) * 25'(SCREEN_WIDTH);
    assign cfix  = crem >= 25'(SCREEN_WIDTH);
    assign cmag  = CAMX_W'(r_cq) + CAMX_W'(r_q1) + CAMX_W'(cfix);

    assign px = $signed(i_cfg.plane_x) * r_camx;
    assign py = $signed(i_cfg.plane_y) * r_camx;

    assign rabsx = r_rdx[RD_W-1] ? DIVD_W'(-r_rdx) : DIVD_W'(r_rdx);
    assign rabsy = r_rdy[RD_W-1] ? DIVD_W'(-r_rdy) : DIVD_W'(r_rdy);

    assign fx = r_rdx[RD_W-1] ? {1'b0, i_cfg.pos_x[15:0]} : 17'h10000 - {1'b0, i_cfg.pos_x[15:0]};
    assign fy = r_rdy[RD_W-1] ? {1'b0, i_cfg.pos_y[15:0]} : 17'h10000 - {1'b0, i_cfg.pos_y[15:0]};
    assign psx  = fx * r_ddx[32:0];
    assign psy  = fy * r_ddy[32:0];
    assign sdx0 = r_ddx[DD_W-1] ? SD_W'({fx, 24'b0}) : SD_W'(psx[49:16]);
    assign sdy0 = r_ddy[DD_W-1] ? SD_W'({fy, 24'b0}) : SD_W'(psy[49:16]);
    assign mx0  = MW'(i_cfg.pos_x[20:16]);
    assign my0  = MW'(i_cfg.pos_y[20:16]);

    assign take_x  = r_sdx < r_sdy;
    assign nmx     = take_x ? (r_mx + (r_rdx[RD_W-1] ? {MW{1'b1}} : MW'(1))) : r_mx;
    assign nmy     = take_x ? r_my : (r_my + (r_rdy[RD_W-1] ? {MW{1'b1}} : MW'(1)));
    assign out_map = nmx[MW-1] || nmy[MW-1] || (nmx >= MW'(MAP_SIZE)) || (nmy >= MW'(MAP_SIZE));

    assign dsub = r_side ? ({1'b0, r_sdy} - (SD_W+1)'(r_ddy))
                         : ({1'b0, r_sdx} - (SD_W+1)'(r_ddx));
    assign dsat = dsub[SD_W] ? '0 : ((dsub > (SD_W+1)'(D_MAX)) ? D_MAX : D_W'(dsub));

    assign wprod  = 32'(r_d) * (r_side ? 32'(r_rdx) : 32'(r_rdy));
    assign tprod  = r_wfrac * 9'(TEX_SIZE);
    assign texx0  = tprod[24:16];
    assign mirror = (!r_side && !r_rdx[RD_W-1] && (r_rdx != '0)) || (r_side && r_rdy[RD_W-1]);
    assign half   = r_lh[LH_W-1:1];
    assign tp     = r_k[21:0] * r_step;

    assign mem_we = (r_state == S_CLEAR) ||
                    ((r_state == S_IDLE) && !i_q_empty && (i_q_item.op == gdr_pkg::OP_WRITE));
    assign mem_wa = (r_state == S_CLEAR) ? r_clr
                    : {AW'(MW'(i_q_item.x)), AW'(MW'(i_q_item.y))};
    assign mem_wd = (r_state == S_CLEAR) ? 4'd0 : i_q_item.val;
    assign mem_ra = {nmx[AW-1:0], nmy[AW-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        if (r_state == S_STEP) begin
            r_cell <= r_map[mem_ra];
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_div_req   = {r_dgo, r_dnum, r_dden};
    assign o_res       = r_res;
    assign o_res_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dgo   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_dgo <= 1'b0;
            if (i_res_pop) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + (2*AW)'(1);
                    if (r_clr == {(2*AW){1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_empty && (i_q_item.op == gdr_pkg::OP_CAST)) begin
                        r_col   <= i_q_item.col;
                        r_neg   <= cdiff[13];
                        r_cab   <= cabs;
                        r_left  <= 1'b0;
                        r_state <= S_CAMA;
                    end
                end
                S_CAMA: begin
                    r_cq    <= 29'(r_cab) * 29'(CQ);
                    r_cx    <= 25'(r_cab) * 25'(CR);
                    r_state <= S_CAMB;
                end
                S_CAMB: begin
                    r_q1    <= cprod[44:32];
                    r_state <= S_CAMC;
                end
                S_CAMC: begin
                    r_camx  <= r_neg ? -cmag : cmag;
                    r_state <= S_RAY;
                end
                S_WAIT: begin
                    if (i_div_rsp.done) begin
                        case (r_kind)
                            DK_DDX: begin
                                r_ddx   <= DD_W'(q);
                                r_state <= S_RY;
                            end
                            DK_DDY: begin
                                r_ddy   <= DD_W'(q);
                                r_state <= S_SIDE;
                            end
                            DK_LH: begin
                                r_lh    <= LH_W'(q);
                                r_state <= S_WALL;
                            end
                            DK_STEP: begin
                                r_step  <= (q > DIVN_W'(TEX_MAX)) ? TEX_MAX : TEXV_W'(q);
                                r_state <= S_TPOS;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RAY: begin
                    r_rdx   <= RD_W'($signed(i_cfg.dir_x)) + RD_W'(px >>> 16);
                    r_rdy   <= RD_W'($signed(i_cfg.dir_y)) + RD_W'(py >>> 16);
                    r_state <= S_RX;
                end
                S_RX: begin
                    if (r_rdx == '0) begin
                        r_ddx   <= {1'b1, {(DD_W-1){1'b0}}};
                        r_state <= S_RY;
                    end else begin
                        r_dnum  <= {1'b1, {(DIVN_W-1){1'b0}}};
                        r_dden  <= rabsx;
                        r_dgo   <= 1'b1;
                        r_kind  <= DK_DDX;
                        r_state <= S_WAIT;
                    end
                end
                S_RY: begin
                    if (r_rdy == '0) begin
                        r_ddy   <= {1'b1, {(DD_W-1){1'b0}}};
                        r_state <= S_SIDE;
                    end else begin
                        r_dnum  <= {1'b1, {(DIVN_W-1){1'b0}}};
                        r_dden  <= rabsy;
                        r_dgo   <= 1'b1;
                        r_kind  <= DK_DDY;
                        r_state <= S_WAIT;
                    end
                end
                S_SIDE: begin
                    r_sdx <= sdx0;
                    r_sdy <= sdy0;
                    r_mx  <= mx0;
                    r_my  <= my0;
                    r_n   <= '0;
                    if ((mx0 >= MW'(MAP_SIZE)) || (my0 >= MW'(MAP_SIZE))) begin
                        r_left  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_n == NW'(STEP_LIMIT)) begin
                        r_left  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_n    <= r_n + NW'(1);
                        r_mx   <= nmx;
                        r_my   <= nmy;
                        r_side <= !take_x;
                        if (take_x) begin
                            r_sdx <= r_sdx + SD_W'(r_ddx);
                        end else begin
                            r_sdy <= r_sdy + SD_W'(r_ddy);
                        end
                        if (out_map) begin
                            r_left  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_state <= (r_cell != 4'd0) ? S_DIST : S_STEP;
                end
                S_DIST: begin
                    r_d     <= dsat;
                    r_state <= S_LH;
                end
                S_LH: begin
                    r_dnum  <= DIVN_W'(SCREEN_HEIGHT * 65536);
                    r_dden  <= (r_d == '0) ? DIVD_W'(1) : DIVD_W'(r_d);
                    r_dgo   <= 1'b1;
                    r_kind  <= DK_LH;
                    r_state <= S_WAIT;
                end
                S_WALL: begin
                    r_wfrac <= (r_side ? i_cfg.pos_x[15:0] : i_cfg.pos_y[15:0]) + wprod[31:16];
                    r_start <= (half >= (LH_W-1)'(H2)) ? 12'd0 : 12'(H2 - int'(half));
                    r_end   <= ((half + (LH_W-1)'(H2)) >= (LH_W-1)'(SCREEN_HEIGHT))
                               ? 12'(SCREEN_HEIGHT - 1) : 12'(half + (LH_W-1)'(H2));
                    r_k     <= (half > (LH_W-1)'(H2)) ? (half - (LH_W-1)'(H2)) : '0;
                    r_state <= S_TEXX;
                end
                S_TEXX: begin
                    r_texx <= mirror ? 8'(9'(TEX_SIZE - 1) - texx0) : 8'(texx0);
                    if (r_lh == '0) begin
                        r_step  <= TEX_MAX;
                        r_state <= S_TPOS;
                    end else begin
                        r_dnum  <= DIVN_W'(TEX_SIZE * 65536);
                        r_dden  <= DIVD_W'(r_lh);
                        r_dgo   <= 1'b1;
                        r_kind  <= DK_STEP;
                        r_state <= S_WAIT;
                    end
                end
                S_TPOS: begin
                    if ((r_k == '0) || (r_step == '0)) begin
                        r_tpos <= '0;
                    end else if (r_k[LH_W-2:22] != '0) begin
                        r_tpos <= TEX_MAX;
                    end else begin
                        r_tpos <= (tp > 44'(TEX_MAX)) ? TEX_MAX : TEXV_W'(tp);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_res_pop) begin
                        r_ov                 <= 1'b1;
                        r_res                <= '0;
                        r_res.column_out     <= r_col;
                        r_res.left_map       <= r_left;
                        if (!r_left) begin
                            r_res.hit_side       <= r_side;
                            r_res.texture_index  <= 3'(r_cell - 4'd1);
                            r_res.wall_distance  <= r_d;
                            r_res.span_start     <= 9'(r_start);
                            r_res.span_end       <= 9'(r_end);
                            r_res.texture_column <= 6'(r_texx);
                            r_res.texture_step   <= r_step;
                            r_res.texture_start  <= r_tpos;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/grid_dda_column_raycaster.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster
// Grid raycaster: map cell writes and per-column DDA ray casts.
// ----------------------------------------------------------------------------
// After reset the map store is swept to empty, one cell per cycle, before the
// first command runs; commands are buffered meanwhile. A map write is stored
// as it leaves the queue. A cast forms its camera offset in the states CAMA,
// CAMB and CAMC by a constant reciprocal multiply and runs its other divisions
// on one shared bit-serial divider: two reciprocals, line height and texture
// step. A zero ray component skips its reciprocal.
// ----------------------------------------------------------------------------
module grid_dda_column_raycaster #(
    parameter int MAP_SIZE      = gdr_pkg::MAP_SIZE_D,
    parameter int SCREEN_WIDTH  = gdr_pkg::SCREEN_WIDTH_D,
    parameter int SCREEN_HEIGHT = gdr_pkg::SCREEN_HEIGHT_D,
    parameter int TEX_SIZE      = gdr_pkg::TEX_SIZE_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [4:0]  i_cell_x,
    input  logic [4:0]  i_cell_y,
    input  logic [3:0]  i_cell_value,
    input  logic [9:0]  i_screen_column,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  o_column_out,
    output logic        o_hit_side,
    output logic [2:0]  o_texture_index,
    output logic [23:0] o_wall_distance,
    output logic [8:0]  o_span_start,
    output logic [8:0]  o_span_end,
    output logic [5:0]  o_texture_column,
    output logic [21:0] o_texture_step,
    output logic [21:0] o_texture_start,
    output logic        o_left_map,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [gdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gdr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    gdr_pkg::t_cfg     r_cfg;
    gdr_pkg::t_item    q_in_item;
    gdr_pkg::t_item    q_out_item;
    gdr_pkg::t_div_req div_req;
    gdr_pkg::t_div_rsp div_rsp;
    gdr_pkg::t_result  res;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic              res_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_x   <= '0;
            r_cfg.pos_y   <= '0;
            r_cfg.dir_x   <= 18'h30000;
            r_cfg.dir_y   <= '0;
            r_cfg.plane_x <= '0;
            r_cfg.plane_y <= 18'h0A8F6;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gdr_pkg::REG_CAM_POS_X:   r_cfg.pos_x   <= i_cfg_data;
                gdr_pkg::REG_CAM_POS_Y:   r_cfg.pos_y   <= i_cfg_data;
                gdr_pkg::REG_VIEW_DIR_X:  r_cfg.dir_x   <= i_cfg_data[17:0];
                gdr_pkg::REG_VIEW_DIR_Y:  r_cfg.dir_y   <= i_cfg_data[17:0];
                gdr_pkg::REG_CAM_PLANE_X: r_cfg.plane_x <= i_cfg_data[17:0];
                gdr_pkg::REG_CAM_PLANE_Y: r_cfg.plane_y <= i_cfg_data[17:0];
                default: begin
                end
            endcase
        end
    end

    gdr_front #(
        .MAP_SIZE (MAP_SIZE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_value    (i_cell_value),
        .i_screen_column (i_screen_column),
        .o_q_push        (q_push),
        .o_q_item        (q_in_item),
        .i_q_full        (q_full)
    );

    gdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    gdr_back #(
        .MAP_SIZE      (MAP_SIZE),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_SIZE      (TEX_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_pop   (pop && res_valid)
    );

    assign empty            = !res_valid;
    assign o_column_out     = res.column_out;
    assign o_hit_side       = res.hit_side;
    assign o_texture_index  = res.texture_index;
    assign o_wall_distance  = res.wall_distance;
    assign o_span_start     = res.span_start;
    assign o_span_end       = res.span_end;
    assign o_texture_column = res.texture_column;
    assign o_texture_step   = res.texture_step;
    assign o_texture_start  = res.texture_start;
    assign o_left_map       = res.left_map;

endmodule

>>> sim/grid_dda_column_raycaster_tb.sv
// ----------------------------------------------------------------------------
// grid_dda_column_raycaster_tb
// Drives map writes and column casts through the queue ports, with camera
// settings changed between phases. Each cast is predicted in fixed point and
// each returned word is compared field by field, in order.
// ----------------------------------------------------------------------------
class raycast_scoreboard;
    logic [3:0]        grid [0:1023];
    longint            pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
    gdr_pkg::t_result  awaited [$];
    int                errors;

    function new();
        foreach (grid[i]) grid[i] = '0;
        pos_x = 0;
        pos_y = 0;
        dir_x = -65536;
        dir_y = 0;
        plane_x = 0;
        plane_y = 43254;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [20:0] data);
        case (idx)
            gdr_pkg::REG_CAM_POS_X:   pos_x = longint'(data);
            gdr_pkg::REG_CAM_POS_Y:   pos_y = longint'(data);
            gdr_pkg::REG_VIEW_DIR_X:  dir_x = longint'($signed(data[17:0]));
            gdr_pkg::REG_VIEW_DIR_Y:  dir_y = longint'($signed(data[17:0]));
            gdr_pkg::REG_CAM_PLANE_X: plane_x = longint'($signed(data[17:0]));
            gdr_pkg::REG_CAM_PLANE_Y: plane_y = longint'($signed(data[17:0]));
            default: ;
        endcase
    endfunction

    function longint floor16(longint p);
        if (p >= 0) return p >>> 16;
        return -(((-p) + 65535) >>> 16);
    endfunction

    function longint inv_len(longint r);
        if (r < 0) r = -r;
        if (r == 0) return longint'(1) << 40;
        return (longint'(1) << 32) / r;
    endfunction

    function longint edge_dist(longint p, longint c, longint dr, longint dl);
        longint frac;
        frac = (dr < 0) ? p - (c << 16) : ((c + 1) << 16) - p;
        return (frac * dl) >>> 16;
    endfunction

    function void note_word(logic mode, logic [4:0] cx, logic [4:0] cy,
                            logic [3:0] val, logic [9:0] col);
        gdr_pkg::t_result r;
        longint camx, rdx, rdy, ddx, ddy, sdx, sdy, mx, my, sx, sy;
        longint d, lh, st, en, wall, texx, stp, tpos;
        logic [3:0] hit;
        bit side, gone;
        if (mode == gdr_pkg::OP_WRITE) begin
            grid[{cx, cy}] = val;
            return;
        end
        r = '0;
        r.column_out = col;
        camx = ((2 * longint'(col) - 640) * 65536) / 640;
        rdx = dir_x + floor16(plane_x * camx);
        rdy = dir_y + floor16(plane_y * camx);
        ddx = inv_len(rdx);
        ddy = inv_len(rdy);
        mx = pos_x >>> 16;
        my = pos_y >>> 16;
        sx = (rdx < 0) ? -1 : 1;
        sy = (rdy < 0) ? -1 : 1;
        sdx = edge_dist(pos_x, mx, rdx, ddx);
        sdy = edge_dist(pos_y, my, rdy, ddy);
        side = 0;
        hit = '0;
        gone = (mx >= 32 || my >= 32);
        for (int n = 0; !gone && n < 68; n++) begin
            if (sdx < sdy) begin
                sdx += ddx;
                mx += sx;
                side = 0;
            end else begin
                sdy += ddy;
                my += sy;
                side = 1;
            end
            if (mx < 0 || my < 0 || mx >= 32 || my >= 32) begin
                gone = 1;
                break;
            end
            hit = grid[mx * 32 + my];
            if (hit != 0) break;
        end
        if (gone || hit == 0) begin
            r.left_map = 1'b1;
            awaited.push_back(r);
            return;
        end
        d = side ? sdy - ddy : sdx - ddx;
        if (d < 0) d = 0;
        if (d > 'hFFFFFF) d = 'hFFFFFF;
        lh = (longint'(480) * 65536) / ((d == 0) ? 1 : d);
        st = 240 - lh / 2;
        if (st < 0) st = 0;
        en = lh / 2 + 240;
        if (en >= 480) en = 479;
        wall = side ? pos_x + floor16(d * rdx) : pos_y + floor16(d * rdy);
        texx = (longint'(wall[15:0]) * 64) >>> 16;
        if ((!side && rdx > 0) || (side && rdy < 0)) texx = 63 - texx;
        if (lh == 0) stp = 'h3FFFFF;
        else begin
            stp = (longint'(64) * 65536) / lh;
            if (stp > 'h3FFFFF) stp = 'h3FFFFF;
        end
        tpos = (st - 240 + lh / 2) * stp;
        if (tpos > 'h3FFFFF) tpos = 'h3FFFFF;
        if (tpos < 0) tpos = 0;
        r.hit_side = side;
        r.texture_index = 3'(hit - 4'd1);
        r.wall_distance = d[23:0];
        r.span_start = st[8:0];
        r.span_end = en[8:0];
        r.texture_column = texx[5:0];
        r.texture_step = stp[21:0];
        r.texture_start = tpos[21:0];
        awaited.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
        if (e != a) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
        end
    endfunction

    function void check_word(gdr_pkg::t_result a);
        gdr_pkg::t_result e;
        if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, column %0d", $time, a.column_out);
            return;
        end
        e = awaited.pop_front();
        cmp("column_out", e.column_out, a.column_out);
        cmp("hit_side", e.hit_side, a.hit_side);
        cmp("texture_index", e.texture_index, a.texture_index);
        cmp("wall_distance", e.wall_distance, a.wall_distance);
        cmp("span_start", e.span_start, a.span_start);
        cmp("span_end", e.span_end, a.span_end);
        cmp("texture_column", e.texture_column, a.texture_column);
        cmp("texture_step", e.texture_step, a.texture_step);
        cmp("texture_start", e.texture_start, a.texture_start);
        cmp("left_map", e.left_map, a.left_map);
    endfunction
endclass

module grid_dda_column_raycaster_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic        i_mode = 0;
    logic [4:0]  i_cell_x = 0;
    logic [4:0]  i_cell_y = 0;
    logic [3:0]  i_cell_value = 0;
    logic [9:0]  i_screen_column = 0;
    logic        empty;
    logic        pop = 0;
    logic [9:0]  o_column_out;
    logic        o_hit_side;
    logic [2:0]  o_texture_index;
    logic [23:0] o_wall_distance;
    logic [8:0]  o_span_start;
    logic [8:0]  o_span_end;
    logic [5:0]  o_texture_column;
    logic [21:0] o_texture_step;
    logic [21:0] o_texture_start;
    logic        o_left_map;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [20:0] i_cfg_data = 0;

    raycast_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    bit running = 0;

    grid_dda_column_raycaster u_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (running && pop && !empty)
            sb.check_word('{o_column_out, o_hit_side, o_texture_index,
                o_wall_distance, o_span_start, o_span_end, o_texture_column,
                o_texture_step, o_texture_start, o_left_map});
    end

    task automatic cfg_write(logic [2:0] idx, logic [20:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic camera(logic [20:0] px, logic [20:0] py, logic [20:0] dx,
                          logic [20:0] dy, logic [20:0] qx, logic [20:0] qy);
        cfg_write(gdr_pkg::REG_CAM_POS_X, px);
        cfg_write(gdr_pkg::REG_CAM_POS_Y, py);
        cfg_write(gdr_pkg::REG_VIEW_DIR_X, dx);
        cfg_write(gdr_pkg::REG_VIEW_DIR_Y, dy);
        cfg_write(gdr_pkg::REG_CAM_PLANE_X, qx);
        cfg_write(gdr_pkg::REG_CAM_PLANE_Y, qy);
        cfg_write(3'($urandom_range(6, 7)), 21'($urandom));
    endtask

    task automatic send(logic mode, logic [4:0] x, logic [4:0] y,
                        logic [3:0] v, logic [9:0] col);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            push <= 0;
            @(negedge i_clk);
        end
        push <= 1;
        i_mode <= mode;
        i_cell_x <= x;
        i_cell_y <= y;
        i_cell_value <= v;
        i_screen_column <= col;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_word(mode, x, y, v, col);
    endtask

    task automatic put_cell(int x, int y, int v);
        send(gdr_pkg::OP_WRITE, 5'(x), 5'(y), 4'(v), 10'($urandom));
    endtask

    task automatic cast(int col);
        send(gdr_pkg::OP_CAST, 5'($urandom), 5'($urandom), 4'($urandom), 10'(col));
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic random_phase();
        for (int i = 0; i < 32; i++) begin
            put_cell(i, 0, $urandom_range(1, 15));
            put_cell(i, 31, $urandom_range(1, 15));
            put_cell(0, i, $urandom_range(1, 15));
            put_cell(31, i, $urandom_range(1, 15));
        end
        for (int i = 0; i < 45; i++) begin
            if ($urandom_range(99) < 55)
                cast(($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(639));
            else
                put_cell($urandom_range(31), $urandom_range(31),
                         $urandom_range(1) ? $urandom_range(15) : 0);
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        running = 1;

        camera(21'h108000, 21'h108000, 21'h3_0000, 21'h0, 21'h0, 21'd43254);
        put_cell(15, 16, 1);
        put_cell(16, 20, 8);
        put_cell(16, 12, 9);
        put_cell(31, 31, 15);
        put_cell(0, 0, 0);
        cast(320);
        cast(0);
        cast(639);
        cast(1023);
        cast(640);
        put_cell(15, 16, 0);
        cast(320);
        put_cell(16, 17, 2);
        put_cell(17, 16, 3);
        cast(320);
        cast(500);
        random_phase();
        drain();

        idle_pct = 68;
        camera(21'h0, 21'h1FFFFF, 21'h2_0000, 21'h0, 21'h1_FFFF, 21'h2_0000);
        random_phase();
        drain();

        idle_pct = 0;
        stall_pct = 68;
        camera(21'($urandom_range(20, 1900000)), 21'($urandom_range(20, 1900000)),
               21'h1_FFFF, 21'($urandom), 21'($urandom), 21'h3FFFF);
        random_phase();
        drain();

        idle_pct = 34;
        stall_pct = 34;
        camera(21'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
               21'($urandom), 21'($urandom));
        random_phase();
        drain();

        if (sb.errors == 0)
            $display("grid_dda_column_raycaster_tb: done, clean");
        else
            $display("grid_dda_column_raycaster_tb: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("grid_dda_column_raycaster_tb: done, errors");
        $finish;
    end
endmodule
